FILE: sv/wsrd_pkg.sv
package wsrd_pkg;

    // result kinds
    localparam logic [1:0] KIND_HDR    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // parser phases
    localparam logic [1:0] PH_HDR0 = 2'd0;
    localparam logic [1:0] PH_HDR1 = 2'd1;
    localparam logic [1:0] PH_EXT  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [3:0] OPC_CLOSE = 4'd8;

    localparam logic [2:0] EXT_LEFT16 = 3'd1;
    localparam logic [2:0] EXT_LEFT64 = 3'd7;

    localparam int LEN_W = 63;

    // command queue between parser and result builder
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    // result queue at the output
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    typedef struct packed {
        logic [1:0]       kind;
        logic             fin;
        logic [3:0]       opcode;
        logic [LEN_W-1:0] payload_len;
        logic [7:0]       data_byte;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       kind;
        logic             fin;
        logic [3:0]       opcode;
        logic [LEN_W-1:0] payload_len;
        logic [7:0]       data_byte;
        logic             last;
        logic [15:0]      close_status;
    } t_res;

endpackage

FILE: sv/websocket_receive_deframer.sv
// Channel   Direction  Handshake          Payload
// receive   in         push / full        i_rx_byte
// result    out        empty / pop        o_kind o_fin o_opcode o_payload_len
//                                         o_data_byte o_last o_close_status
//
// One byte a cycle is taken while full is low; each byte that yields a result
// is written into the command queue at its accepting edge, then moved by the
// result builder into the result queue, where it can be popped (parser,
// command queue, result builder, result queue). Sustained rate is one byte
// per cycle while full stays low; the parser's 63-bit length decrement is combinational.
// Reset is synchronous and active low; it returns the parser to the first
// header byte, reopens a closed connection and empties both queues.
// A stalled result side backs up the four-entry command queue; full rises
// only once that queue is full.
module websocket_receive_deframer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_rx_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [1:0]                 o_kind,
    output logic                       o_fin,
    output logic [3:0]                 o_opcode,
    output logic [wsrd_pkg::LEN_W-1:0] o_payload_len,
    output logic [7:0]                 o_data_byte,
    output logic                       o_last,
    output logic [15:0]                o_close_status
);
    import wsrd_pkg::*;

    logic take;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_empty;
    logic cmd_pop;
    t_cmd cmd_out;
    t_res res;

    // accept a transaction only when the command queue has room
    assign take = push && !full;

    // front: parse header bytes, classify each byte, raise commands
    wsrd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_rx_byte  (i_rx_byte),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // hold commands so parser and result builder stall independently
    wsrd_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    // back: build the close status and queue the finished results
    wsrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_kind         = res.kind;
    assign o_fin          = res.fin;
    assign o_opcode       = res.opcode;
    assign o_payload_len  = res.payload_len;
    assign o_data_byte    = res.data_byte;
    assign o_last         = res.last;
    assign o_close_status = res.close_status;

    // a rejected result carries nothing but its kind
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_REJECT) |->
            (!o_last && o_close_status == '0 && o_payload_len == '0))
        else $error("rejected result carries frame fields");

    // a close status only appears on the last result of a close frame
    a_close_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_close_status != '0) |->
            (o_last && o_opcode == OPC_CLOSE && o_kind == KIND_DATA))
        else $error("close status outside last byte of a close frame");

    // a header that ends its frame must announce an empty payload
    a_empty_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == KIND_HDR && o_last) |-> (o_payload_len == '0))
        else $error("final header with non-empty payload");

    // a result taken while the command queue was idle cannot appear from nowhere
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(empty) && $past(cmd_empty) && !$past(cmd_push)) |-> empty)
        else $error("result appeared without a command");

endmodule

FILE: sv/wsrd_front.sv
module wsrd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic [7:0]     i_rx_byte,
    output logic           o_cmd_push,
    output wsrd_pkg::t_cmd o_cmd
);
    import wsrd_pkg::*;

    logic [1:0]       r_phase, n_phase;
    logic             r_fin, n_fin;
    logic [3:0]       r_opc, n_opc;
    logic [2:0]       r_ext, n_ext;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_rem, n_rem;
    logic             r_closed, n_closed;

    logic             hdr_emit;
    logic [LEN_W-1:0] hdr_len;
    logic             hdr_empty;
    logic             data_last;

    always_comb begin
        n_phase    = r_phase;
        n_fin      = r_fin;
        n_opc      = r_opc;
        n_ext      = r_ext;
        n_len      = r_len;
        n_rem      = r_rem;
        n_closed   = r_closed;
        hdr_emit   = 1'b0;
        hdr_len    = {{(LEN_W-7){1'b0}}, i_rx_byte[6:0]};
        hdr_empty  = 1'b0;
        data_last  = (r_rem == {{(LEN_W-1){1'b0}}, 1'b1});
        o_cmd_push = 1'b0;
        o_cmd      = '0;

        if (i_take) begin
            if (r_closed) begin
                o_cmd_push = 1'b1;
                o_cmd.kind = KIND_REJECT;
            end else begin
                case (r_phase)
                    PH_HDR0: begin
                        n_fin   = i_rx_byte[7];
                        n_opc   = i_rx_byte[3:0];
                        n_phase = PH_HDR1;
                    end
                    PH_HDR1: begin
                        n_len = '0;
                        if (i_rx_byte[6:0] == LEN_EXT16) begin
                            n_ext   = EXT_LEFT16;
                            n_phase = PH_EXT;
                        end else if (i_rx_byte[6:0] == LEN_EXT64) begin
                            n_ext   = EXT_LEFT64;
                            n_phase = PH_EXT;
                        end else begin
                            hdr_emit = 1'b1;
                        end
                    end
                    PH_EXT: begin
                        hdr_len = {r_len[LEN_W-9:0], i_rx_byte};
                        n_len   = hdr_len;
                        if (r_ext == 3'd0) begin
                            hdr_emit = 1'b1;
                        end else begin
                            n_ext = r_ext - 3'd1;
                        end
                    end
                    default: begin
                        n_rem             = r_rem - {{(LEN_W-1){1'b0}}, 1'b1};
                        o_cmd_push        = 1'b1;
                        o_cmd.kind        = KIND_DATA;
                        o_cmd.fin         = r_fin;
                        o_cmd.opcode      = r_opc;
                        o_cmd.payload_len = r_len;
                        o_cmd.data_byte   = i_rx_byte;
                        o_cmd.last        = data_last;
                        if (data_last) begin
                            n_phase = PH_HDR0;
                            if (r_opc == OPC_CLOSE) begin
                                n_closed = 1'b1;
                            end
                        end
                    end
                endcase

                hdr_empty = (hdr_len == '0);

                if (hdr_emit) begin
                    n_len             = hdr_len;
                    n_rem             = hdr_len;
                    o_cmd_push        = 1'b1;
                    o_cmd.kind        = KIND_HDR;
                    o_cmd.fin         = r_fin;
                    o_cmd.opcode      = r_opc;
                    o_cmd.payload_len = hdr_len;
                    o_cmd.last        = hdr_empty;
                    if (hdr_empty) begin
                        n_phase = PH_HDR0;
                        if (r_opc == OPC_CLOSE) begin
                            n_closed = 1'b1;
                        end
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_fin    <= 1'b0;
            r_opc    <= '0;
            r_ext    <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_closed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opc    <= n_opc;
            r_ext    <= n_ext;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_closed <= n_closed;
        end
    end

endmodule

FILE: sv/wsrd_cmd_q.sv
module wsrd_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsrd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output wsrd_pkg::t_cmd o_cmd
);
    import wsrd_pkg::*;

    t_cmd             r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr, n_wr;
    logic [CMDQ_AW-1:0] r_rd, n_rd;
    logic [CMDQ_AW:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full  = (r_cnt == CMDQ_DEPTH[CMDQ_AW:0]);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: sv/wsrd_back.sv
module wsrd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  wsrd_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output wsrd_pkg::t_res o_res
);
    import wsrd_pkg::*;

    t_res               r_q [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wr, r_rd;
    logic [RESQ_AW:0]   r_cnt, n_cnt;
    logic               full, do_pop;

    logic [1:0] r_pos, n_pos;
    logic [7:0] r_hi, n_hi;
    logic [7:0] r_lo, n_lo;
    t_res       res;

    assign full      = (r_cnt == RESQ_DEPTH[RESQ_AW:0]);
    assign o_empty   = (r_cnt == '0);
    assign o_res     = r_q[r_rd];
    assign o_cmd_pop = i_cmd_valid && !full;
    assign do_pop    = i_pop && !o_empty;

    // track the first two payload bytes of each frame for the close status
    always_comb begin
        n_pos = r_pos;
        n_hi  = r_hi;
        n_lo  = r_lo;
        res.kind         = i_cmd.kind;
        res.fin          = i_cmd.fin;
        res.opcode       = i_cmd.opcode;
        res.payload_len  = i_cmd.payload_len;
        res.data_byte    = i_cmd.data_byte;
        res.last         = i_cmd.last;
        res.close_status = '0;
        case (i_cmd.kind)
            KIND_HDR: begin
                n_pos = 2'd0;
            end
            KIND_DATA: begin
                if (r_pos == 2'd0) begin
                    n_hi = i_cmd.data_byte;
                end
                if (r_pos == 2'd1) begin
                    n_lo = i_cmd.data_byte;
                end
                if (r_pos != 2'd2) begin
                    n_pos = r_pos + 2'd1;
                end
                if (i_cmd.last && i_cmd.opcode == OPC_CLOSE && n_pos == 2'd2) begin
                    res.close_status = {n_hi, n_lo};
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (o_cmd_pop && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !o_cmd_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_q[r_wr] <= res;
            r_hi      <= n_hi;
            r_lo      <= n_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
            r_pos <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (o_cmd_pop) begin
                r_wr  <= r_wr + 1'b1;
                r_pos <= n_pos;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

FILE: dv/deframer_checker.sv
`timescale 1ns / 100ps

module deframer_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [7:0]                 i_rx_byte,
    input  logic                       i_empty,
    input  logic                       i_pop,
    input  logic [1:0]                 i_kind,
    input  logic                       i_fin,
    input  logic [3:0]                 i_opcode,
    input  logic [wsrd_pkg::LEN_W-1:0] i_payload_len,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_last,
    input  logic [15:0]                i_close_status,
    output int                         o_fail_count,
    output int                         o_pending
);
    import wsrd_pkg::*;

    localparam int MAX_PRINTS = 30;

    // parser state mirrored from the block's behaviour
    logic [1:0]       ph;
    logic             fr_fin;
    logic [3:0]       fr_opc;
    logic [2:0]       ext_left;
    logic [LEN_W-1:0] frame_len;
    logic [LEN_W-1:0] left_len;
    logic [7:0]       code_hi;
    logic [7:0]       code_lo;
    logic [1:0]       seen;
    logic             is_closed;

    t_res results_due[$];
    int   errors = 0;

    task report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task queue_result(input logic [1:0] kind, input logic [7:0] data, input logic last,
                      input logic [15:0] code);
        t_res r;
        r.kind         = kind;
        r.fin          = fr_fin;
        r.opcode       = fr_opc;
        r.payload_len  = frame_len;
        r.data_byte    = data;
        r.last         = last;
        r.close_status = code;
        results_due.push_back(r);
    endtask

    // a close frame shuts the connection once its last result is out
    task finish_frame();
        if (fr_opc == OPC_CLOSE)
            is_closed = 1'b1;
        ph = PH_HDR0;
    endtask

    task open_frame();
        left_len = frame_len;
        seen     = 2'd0;
        code_hi  = 8'd0;
        code_lo  = 8'd0;
        if (frame_len == '0) begin
            queue_result(KIND_HDR, 8'd0, 1'b1, 16'd0);
            finish_frame();
        end else begin
            queue_result(KIND_HDR, 8'd0, 1'b0, 16'd0);
            ph = PH_DATA;
        end
    endtask

    task parse_byte(input logic [7:0] b);
        t_res        rej;
        logic        is_last;
        logic [15:0] code;
        if (is_closed) begin
            rej      = '0;
            rej.kind = KIND_REJECT;
            results_due.push_back(rej);
        end else begin
            case (ph)
                PH_HDR0: begin
                    fr_fin = b[7];
                    fr_opc = b[3:0];
                    ph     = PH_HDR1;
                end
                PH_HDR1: begin
                    frame_len = '0;
                    if (b[6:0] == LEN_EXT16) begin
                        ext_left = EXT_LEFT16;
                        ph       = PH_EXT;
                    end else if (b[6:0] == LEN_EXT64) begin
                        ext_left = EXT_LEFT64;
                        ph       = PH_EXT;
                    end else begin
                        frame_len[6:0] = b[6:0];
                        open_frame();
                    end
                end
                PH_EXT: begin
                    // bit 63 of a 64-bit length falls off the top
                    frame_len = {frame_len[LEN_W-9:0], b};
                    if (ext_left == 3'd0)
                        open_frame();
                    else
                        ext_left = ext_left - 3'd1;
                end
                default: begin
                    if (seen == 2'd0)
                        code_hi = b;
                    else if (seen == 2'd1)
                        code_lo = b;
                    if (seen < 2'd2)
                        seen = seen + 2'd1;
                    left_len = left_len - 1'b1;
                    is_last  = (left_len == '0);
                    code     = (is_last && fr_opc == OPC_CLOSE && seen == 2'd2) ?
                               {code_hi, code_lo} : 16'd0;
                    queue_result(KIND_DATA, b, is_last, code);
                    if (is_last)
                        finish_frame();
                end
            endcase
        end
    endtask

    task check_result();
        t_res want;
        if (results_due.size() == 0) begin
            report_mismatch("result with nothing expected, kind", 64'(i_kind), 64'd0);
        end else begin
            want = results_due.pop_front();
            if (i_kind != want.kind)
                report_mismatch("kind", 64'(i_kind), 64'(want.kind));
            if (i_fin != want.fin)
                report_mismatch("fin", 64'(i_fin), 64'(want.fin));
            if (i_opcode != want.opcode)
                report_mismatch("opcode", 64'(i_opcode), 64'(want.opcode));
            if (i_payload_len != want.payload_len)
                report_mismatch("payload_len", 64'(i_payload_len), 64'(want.payload_len));
            if (i_data_byte != want.data_byte)
                report_mismatch("data_byte", 64'(i_data_byte), 64'(want.data_byte));
            if (i_last != want.last)
                report_mismatch("last", 64'(i_last), 64'(want.last));
            if (i_close_status != want.close_status)
                report_mismatch("close_status", 64'(i_close_status),
                                64'(want.close_status));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ph        = PH_HDR0;
            fr_fin    = 1'b0;
            fr_opc    = 4'd0;
            ext_left  = 3'd0;
            frame_len = '0;
            left_len  = '0;
            code_hi   = 8'd0;
            code_lo   = 8'd0;
            seen      = 2'd0;
            is_closed = 1'b0;
            results_due.delete();
        end else begin
            // results leave only after their byte has been taken, so check first
            if (i_pop && !i_empty)
                check_result();
            if (i_push && !i_full)
                parse_byte(i_rx_byte);
        end
        o_pending    <= results_due.size();
        o_fail_count <= errors;
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wsrd_pkg::*;

    // opcodes used for ordinary frames; close comes from the package
    localparam logic [3:0] OPC_CONT = 4'd0;
    localparam logic [3:0] OPC_TEXT = 4'd1;
    localparam logic [3:0] OPC_BIN  = 4'd2;
    localparam logic [3:0] OPC_PING = 4'd9;
    localparam logic [3:0] OPC_PONG = 4'd10;

    localparam int RANDOM_BYTES = 1500;
    // cycles with no transaction on either side before the run is abandoned;
    // far above the longest receiver stall plus the pipeline
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       push      = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       pop       = 1'b0;

    logic             full;
    logic             empty;
    logic [1:0]       o_kind;
    logic             o_fin;
    logic [3:0]       o_opcode;
    logic [LEN_W-1:0] o_payload_len;
    logic [7:0]       o_data_byte;
    logic             o_last;
    logic [15:0]      o_close_status;

    int fail_count;
    int results_pending;

    int n_sent     = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int stall_mode  = 0;
    int mode_cycles = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    websocket_receive_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_fin          (o_fin),
        .o_opcode       (o_opcode),
        .o_payload_len  (o_payload_len),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last),
        .o_close_status (o_close_status)
    );

    deframer_checker u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_rx_byte      (i_rx_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_kind         (o_kind),
        .i_fin          (o_fin),
        .i_opcode       (o_opcode),
        .i_payload_len  (o_payload_len),
        .i_data_byte    (o_data_byte),
        .i_last         (o_last),
        .i_close_status (o_close_status),
        .o_fail_count   (fail_count),
        .o_pending      (results_pending)
    );

    // Receiver: switch between free-running pop, light and heavy random
    // stalls, and a dead stop that can last long enough to back the command
    // queue up until full rises.
    always @(posedge i_clk) begin
        if (mode_cycles == 0) begin
            stall_mode  <= $urandom_range(0, 3);
            mode_cycles <= $urandom_range(1, 60);
        end else begin
            mode_cycles <= mode_cycles - 1;
        end
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= 1'b0;
        endcase
    end

    // Watchdog: reset the count on any transaction, give up when it runs out.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Offer one byte and hold it until the block takes it. The full seen
    // right after the edge is still the value the block sampled at it.
    // Between bursts drop push for a random gap; some bursts run back to
    // back so that stretches of the stream see no gaps at all.
    task send_byte(input logic [7:0] b);
        int gap;
        push      <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Send one well-formed frame. Reserved bits, fin and the mask bit are
    // random; short lengths sometimes go out in the 16- or 64-bit form as
    // well (non-minimal encodings), and the 64-bit form may carry bit 63,
    // which the block drops.
    task send_frame(input logic [3:0] opc, input int len);
        logic        fin_bit;
        logic        mask_bit;
        logic [2:0]  rsv_bits;
        logic [63:0] ext_len;
        int          form;
        fin_bit  = 1'($urandom_range(0, 1));
        mask_bit = 1'($urandom_range(0, 1));
        rsv_bits = 3'($urandom_range(0, 7));
        if (len > 125)
            form = $urandom_range(1, 2);
        else
            form = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2);
        send_byte({fin_bit, rsv_bits, opc});
        case (form)
            0: send_byte({mask_bit, 7'(len)});
            1: begin
                send_byte({mask_bit, LEN_EXT16});
                send_byte(8'(len >> 8));
                send_byte(8'(len));
            end
            default: begin
                send_byte({mask_bit, LEN_EXT64});
                ext_len        = 64'(len);
                ext_len[63]    = 1'($urandom_range(0, 1));
                for (int i = 7; i >= 0; i--)
                    send_byte(ext_len[i*8 +: 8]);
            end
        endcase
        repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [3:0] opc;
        int         len;
        int         pick;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty frame: the header is also the last result
        send_byte({1'b1, 3'b000, OPC_TEXT});
        send_byte(8'h00);
        // mask bit set, payload passes through unmasked; byte extremes
        send_byte({1'b0, 3'b000, OPC_BIN});
        send_byte({1'b1, 7'd3});
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        // reserved bits set, a 16-bit length carrying a small value
        send_byte({1'b1, 3'b111, OPC_CONT});
        send_byte({1'b0, LEN_EXT16});
        send_byte(8'h00);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);
        // a 16-bit length of zero gives an empty frame
        send_byte({1'b1, 3'b000, OPC_PING});
        send_byte({1'b1, LEN_EXT16});
        send_byte(8'h00);
        send_byte(8'h00);
        // 64-bit length with bit 63 set: only the low 63 bits count
        send_byte({1'b1, 3'b000, OPC_PONG});
        send_byte({1'b1, LEN_EXT64});
        send_byte(8'h80);
        repeat (6) send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hA5);

        // Random frames; close is held back because it shuts the
        // connection for the rest of the run.
        while (n_sent < RANDOM_BYTES) begin
            opc = 4'($urandom_range(0, 14));
            if (opc >= OPC_CLOSE)
                opc = opc + 4'd1;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = 0;
            else if (pick < 85)
                len = $urandom_range(1, 12);
            else if (pick < 97)
                len = $urandom_range(13, 125);
            else
                len = $urandom_range(126, 300);
            send_frame(opc, len);
        end

        // Close frame with a short payload (too short for a code now and
        // then), then bytes that must all come back rejected.
        send_frame(OPC_CLOSE, $urandom_range(0, 4));
        repeat (8) send_byte(8'($urandom_range(0, 255)));
        push <= 1'b0;

        // drain every outstanding transaction, then watch for strays
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/wsrd_pkg.sv
sv/wsrd_front.sv
sv/wsrd_cmd_q.sv
sv/wsrd_back.sv
sv/websocket_receive_deframer.sv
dv/deframer_checker.sv
dv/tb_top.sv
